[hw/rtl/ecgmbf_pkg.sv]
// ----------------------------------------------------------------------------
// ecgmbf_pkg
// Shared constants and types for the ECG mains and baseline filter: tap
// counts, datapath widths and the reciprocal constants of its two divisors.
// ----------------------------------------------------------------------------
`default_nettype none

package ecgmbf_pkg;

    // filter configuration
    localparam int MAINS_TAPS = 10;
    localparam int BASE_TAPS  = 256;
    localparam int CHANNELS   = 2;

    // field widths
    localparam int CHAN_W = 1;
    localparam int SMP_W  = 24;
    localparam int SM_W   = 25;
    localparam int RES_W  = 26;

    // index widths
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RH_W = (MAINS_TAPS > 1) ? $clog2(MAINS_TAPS) : 1;
    localparam int LH_W = (BASE_TAPS > 1) ? $clog2(BASE_TAPS) : 1;

    // pipeline depth from request accept to the output register input
    localparam int PIPE_STAGES = 11;

    // short moving sum and its divide by MAINS_TAPS/2 (exact reciprocal)
    localparam int RAW_SUM_W  = SMP_W + $clog2(MAINS_TAPS);
    localparam int RAW_DIV    = MAINS_TAPS / 2;
    localparam int RAW_S      = RAW_SUM_W + $clog2(RAW_DIV);
    localparam int RAW_M_W    = RAW_SUM_W + 1;
    localparam logic [RAW_M_W-1:0] RAW_M =
        RAW_M_W'(((64'd1 << RAW_S) + 64'(RAW_DIV) - 64'd1) / 64'(RAW_DIV));
    localparam int RAW_PROD_W = RAW_SUM_W + RAW_M_W;
    localparam int RAW_Q_W    = RAW_PROD_W - RAW_S;

    // long moving sums and their divide by BASE_TAPS (exact reciprocal)
    localparam int LONG_SUM_W  = SM_W + $clog2(BASE_TAPS);
    localparam int LONG_S      = LONG_SUM_W + $clog2(BASE_TAPS);
    localparam int LONG_M_W    = LONG_SUM_W + 1;
    localparam logic [LONG_M_W-1:0] LONG_M =
        LONG_M_W'(((64'd1 << LONG_S) + 64'(BASE_TAPS) - 64'd1) / 64'(BASE_TAPS));
    localparam int LO_W        = (LONG_SUM_W + 1) / 2;
    localparam int HI_W        = LONG_SUM_W - LO_W;
    localparam int PL_W        = LO_W + LONG_M_W;
    localparam int PH_W        = HI_W + LONG_M_W;
    localparam int LONG_PROD_W = LONG_SUM_W + LONG_M_W;
    localparam int LQ_W        = LONG_PROD_W - LONG_S;

    // smoothed value limits
    localparam logic [RAW_Q_W-1:0] SM_POS_LIM = RAW_Q_W'((64'd1 << (SM_W - 1)) - 64'd1);
    localparam logic [RAW_Q_W-1:0] SM_NEG_LIM = RAW_Q_W'(64'd1 << (SM_W - 1));
    localparam logic signed [SM_W-1:0] SM_MAX = {1'b0, {(SM_W - 1){1'b1}}};
    localparam logic signed [SM_W-1:0] SM_MIN = {1'b1, {(SM_W - 1){1'b0}}};

    // per-request context carried down the pipeline
    typedef struct packed {
        logic             chan;
        logic             pres;
        logic [RH_W-1:0]  rh;
        logic             rfull;
        logic [LH_W-1:0]  lh;
        logic             lfull;
    } ctx_t;

endpackage

`default_nettype wire

[hw/rtl/ecg_mains_and_baseline_filter.sv]
// ----------------------------------------------------------------------------
// ecg_mains_and_baseline_filter
// Each request passes through the pipeline stages and then the output register.
// Throughput: one request per cycle, any mix of channels; the pipeline stalls
// as a whole only while a result waits at the output.
// Reset clears heads, sums and ring fill flags; ring memories are not swept,
// an entry not yet written since reset reads as zero through its fill flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ecg_mains_and_baseline_filter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_ready,
    input  wire logic [ecgmbf_pkg::CHAN_W-1:0]        channel,
    input  wire logic signed [ecgmbf_pkg::SMP_W-1:0]  sample,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_ready,
    output logic [ecgmbf_pkg::CHAN_W-1:0]             channel_out,
    output logic signed [ecgmbf_pkg::RES_W-1:0]       filtered
);

    // pipeline control
    logic                                   adv;
    logic                                   acc;
    logic [ecgmbf_pkg::PIPE_STAGES:1]       vld_reg;
    ecgmbf_pkg::ctx_t                       ctx_reg [1:ecgmbf_pkg::PIPE_STAGES];
    ecgmbf_pkg::ctx_t                       ctx_a;
    logic [ecgmbf_pkg::CH_W-1:0]            ch_a;

    // per-channel state in flip-flops
    logic [ecgmbf_pkg::RH_W-1:0]            raw_head_reg  [ecgmbf_pkg::CHANNELS];
    logic                                   raw_full_reg  [ecgmbf_pkg::CHANNELS];
    logic [ecgmbf_pkg::LH_W-1:0]            long_head_reg [ecgmbf_pkg::CHANNELS];
    logic                                   long_full_reg [ecgmbf_pkg::CHANNELS];
    logic signed [ecgmbf_pkg::RAW_SUM_W-1:0]  raw_sum_reg    [ecgmbf_pkg::CHANNELS];
    logic signed [ecgmbf_pkg::LONG_SUM_W-1:0] smooth_sum_reg [ecgmbf_pkg::CHANNELS];
    logic signed [ecgmbf_pkg::LONG_SUM_W-1:0] base_sum_reg   [ecgmbf_pkg::CHANNELS];

    // ring memories
    logic signed [ecgmbf_pkg::SMP_W-1:0]
        raw_ring [ecgmbf_pkg::CHANNELS][ecgmbf_pkg::MAINS_TAPS];
    logic signed [ecgmbf_pkg::SM_W-1:0]
        smooth_ring [ecgmbf_pkg::CHANNELS][ecgmbf_pkg::BASE_TAPS];
    logic signed [ecgmbf_pkg::SM_W-1:0]
        base_ring [ecgmbf_pkg::CHANNELS][ecgmbf_pkg::BASE_TAPS];

    // stage 1: short ring read data and raw sample
    logic signed [ecgmbf_pkg::SMP_W-1:0]      raw_rd_reg;
    logic signed [ecgmbf_pkg::SMP_W-1:0]      x1_reg;
    logic [ecgmbf_pkg::CH_W-1:0]              ch1;
    logic                                     wr1;
    logic signed [ecgmbf_pkg::SMP_W-1:0]      raw_old;
    logic signed [ecgmbf_pkg::RAW_SUM_W-1:0]  raw_sum_next;

    // stages 2-3: divide by MAINS_TAPS/2
    logic                                     rneg2_reg;
    logic [ecgmbf_pkg::RAW_SUM_W-1:0]         rmag2_reg;
    logic [ecgmbf_pkg::RAW_PROD_W-1:0]        raw_prod;
    logic                                     rneg3_reg;
    logic [ecgmbf_pkg::RAW_Q_W-1:0]           rq3_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       smooth_c;

    // smoothed value carried to the end
    logic signed [ecgmbf_pkg::SM_W-1:0]       smooth_reg [4:ecgmbf_pkg::PIPE_STAGES];

    // stages 3-4: smooth ring read-modify-write
    logic [ecgmbf_pkg::CH_W-1:0]              ch3;
    logic [ecgmbf_pkg::CH_W-1:0]              ch4;
    logic                                     rd3;
    logic                                     wr4;
    logic                                     byp3;
    logic signed [ecgmbf_pkg::SM_W-1:0]       sm_rd_reg;
    logic                                     sm_byp_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       sm_byp_data_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       sm_old;
    logic signed [ecgmbf_pkg::LONG_SUM_W-1:0] ssum_next;

    // stages 5-7: first average
    logic                                     a1n5_reg;
    logic [ecgmbf_pkg::LONG_SUM_W-1:0]        a1mag5_reg;
    logic [ecgmbf_pkg::PL_W-1:0]              a1_pl;
    logic [ecgmbf_pkg::PH_W-1:0]              a1_ph;
    logic                                     a1n6_reg;
    logic [ecgmbf_pkg::PL_W-1:0]              a1pl6_reg;
    logic [ecgmbf_pkg::PH_W-1:0]              a1ph6_reg;
    logic [ecgmbf_pkg::LONG_PROD_W-1:0]       a1_prod;
    logic [ecgmbf_pkg::LQ_W-1:0]              a1_q;
    logic                                     a1n7_reg;
    logic [ecgmbf_pkg::SM_W-1:0]              q1_7_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       avg1_c;

    // stages 7-8: base ring read-modify-write
    logic [ecgmbf_pkg::CH_W-1:0]              ch7;
    logic [ecgmbf_pkg::CH_W-1:0]              ch8;
    logic                                     rd7;
    logic                                     wr8;
    logic                                     byp7;
    logic signed [ecgmbf_pkg::SM_W-1:0]       avg1_8_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       b_rd_reg;
    logic                                     b_byp_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       b_byp_data_reg;
    logic signed [ecgmbf_pkg::SM_W-1:0]       b_old;
    logic signed [ecgmbf_pkg::LONG_SUM_W-1:0] bsum_next;

    // stages 9-11: second average and result
    logic                                     a2n9_reg;
    logic [ecgmbf_pkg::LONG_SUM_W-1:0]        a2mag9_reg;
    logic [ecgmbf_pkg::PL_W-1:0]              a2_pl;
    logic [ecgmbf_pkg::PH_W-1:0]              a2_ph;
    logic                                     a2n10_reg;
    logic [ecgmbf_pkg::PL_W-1:0]              a2pl10_reg;
    logic [ecgmbf_pkg::PH_W-1:0]              a2ph10_reg;
    logic [ecgmbf_pkg::LONG_PROD_W-1:0]       a2_prod;
    logic [ecgmbf_pkg::LQ_W-1:0]              a2_q;
    logic                                     a2n11_reg;
    logic [ecgmbf_pkg::SM_W-1:0]              q2_11_reg;
    logic [ecgmbf_pkg::RES_W-1:0]             res_c;

    // output register
    logic                                     rsp_valid_reg;
    logic [ecgmbf_pkg::CHAN_W-1:0]            channel_out_reg;
    logic signed [ecgmbf_pkg::RES_W-1:0]      filtered_reg;

    // handshake: whole pipeline moves when the output slot is free or taken
    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign acc       = req_valid && adv;

    // request context: heads and fill flags of the addressed channel
    always_comb
    begin
        ch_a        = ecgmbf_pkg::CH_W'(channel);
        ctx_a.chan  = channel;
        ctx_a.pres  = (int'(channel) < ecgmbf_pkg::CHANNELS);
        ctx_a.rh    = raw_head_reg[ch_a];
        ctx_a.rfull = raw_full_reg[ch_a];
        ctx_a.lh    = long_head_reg[ch_a];
        ctx_a.lfull = long_full_reg[ch_a];
    end

    // head pointers and fill flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ecgmbf_pkg::CHANNELS; i++)
            begin
                raw_head_reg[i]  <= '0;
                raw_full_reg[i]  <= 1'b0;
                long_head_reg[i] <= '0;
                long_full_reg[i] <= 1'b0;
            end
        end
        else if (acc && ctx_a.pres)
        begin
            if (ctx_a.rh == ecgmbf_pkg::RH_W'(ecgmbf_pkg::MAINS_TAPS - 1))
            begin
                raw_head_reg[ch_a] <= '0;
                raw_full_reg[ch_a] <= 1'b1;
            end
            else
            begin
                raw_head_reg[ch_a] <= ctx_a.rh + 1'b1;
            end
            if (ctx_a.lh == ecgmbf_pkg::LH_W'(ecgmbf_pkg::BASE_TAPS - 1))
            begin
                long_head_reg[ch_a] <= '0;
                long_full_reg[ch_a] <= 1'b1;
            end
            else
            begin
                long_head_reg[ch_a] <= ctx_a.lh + 1'b1;
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[ecgmbf_pkg::PIPE_STAGES-1:1], acc};
            rsp_valid_reg <= vld_reg[ecgmbf_pkg::PIPE_STAGES];
        end
    end

    // context and smoothed value shift
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[1] <= ctx_a;
            for (int k = 2; k <= ecgmbf_pkg::PIPE_STAGES; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            smooth_reg[4] <= smooth_c;
            for (int k = 5; k <= ecgmbf_pkg::PIPE_STAGES; k++)
            begin
                smooth_reg[k] <= smooth_reg[k-1];
            end
        end
    end

    // short ring memory: read at accept, write back one stage later
    assign ch1 = ecgmbf_pkg::CH_W'(ctx_reg[1].chan);
    assign wr1 = adv && vld_reg[1] && ctx_reg[1].pres;

    always_ff @(posedge clk)
    begin
        if (acc && ctx_a.pres)
        begin
            raw_rd_reg <= raw_ring[ch_a][ctx_a.rh];
        end
        if (wr1)
        begin
            raw_ring[ch1][ctx_reg[1].rh] <= x1_reg;
        end
    end

    // stage 1: update short moving sum
    always_comb
    begin
        raw_old      = ctx_reg[1].rfull ? raw_rd_reg : '0;
        raw_sum_next = raw_sum_reg[ch1] + ecgmbf_pkg::RAW_SUM_W'(x1_reg)
                       - ecgmbf_pkg::RAW_SUM_W'(raw_old);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ecgmbf_pkg::CHANNELS; i++)
            begin
                raw_sum_reg[i] <= '0;
            end
        end
        else if (wr1)
        begin
            raw_sum_reg[ch1] <= raw_sum_next;
        end
    end

    // stage 2: reciprocal multiply for the short divide
    assign raw_prod = ecgmbf_pkg::RAW_PROD_W'(rmag2_reg)
                      * ecgmbf_pkg::RAW_PROD_W'(ecgmbf_pkg::RAW_M);

    // stage 3: restore sign and saturate to the smoothed width
    always_comb
    begin
        if (!rneg3_reg && (rq3_reg > ecgmbf_pkg::SM_POS_LIM))
        begin
            smooth_c = ecgmbf_pkg::SM_MAX;
        end
        else if (rneg3_reg && (rq3_reg > ecgmbf_pkg::SM_NEG_LIM))
        begin
            smooth_c = ecgmbf_pkg::SM_MIN;
        end
        else if (rneg3_reg)
        begin
            smooth_c = -$signed(ecgmbf_pkg::SM_W'(rq3_reg));
        end
        else
        begin
            smooth_c = $signed(ecgmbf_pkg::SM_W'(rq3_reg));
        end
    end

    // smooth ring memory: read in stage 3, write back in stage 4
    assign ch3  = ecgmbf_pkg::CH_W'(ctx_reg[3].chan);
    assign ch4  = ecgmbf_pkg::CH_W'(ctx_reg[4].chan);
    assign rd3  = adv && vld_reg[3] && ctx_reg[3].pres;
    assign wr4  = adv && vld_reg[4] && ctx_reg[4].pres;
    assign byp3 = wr4 && (ctx_reg[4].chan == ctx_reg[3].chan)
                  && (ctx_reg[4].lh == ctx_reg[3].lh);

    always_ff @(posedge clk)
    begin
        if (rd3)
        begin
            sm_rd_reg       <= smooth_ring[ch3][ctx_reg[3].lh];
            sm_byp_reg      <= byp3;
            sm_byp_data_reg <= smooth_reg[4];
        end
        if (wr4)
        begin
            smooth_ring[ch4][ctx_reg[4].lh] <= smooth_reg[4];
        end
    end

    // stage 4: update smooth moving sum
    always_comb
    begin
        if (!ctx_reg[4].lfull)
        begin
            sm_old = '0;
        end
        else if (sm_byp_reg)
        begin
            sm_old = sm_byp_data_reg;
        end
        else
        begin
            sm_old = sm_rd_reg;
        end
        ssum_next = smooth_sum_reg[ch4] + ecgmbf_pkg::LONG_SUM_W'(smooth_reg[4])
                    - ecgmbf_pkg::LONG_SUM_W'(sm_old);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ecgmbf_pkg::CHANNELS; i++)
            begin
                smooth_sum_reg[i] <= '0;
            end
        end
        else if (wr4)
        begin
            smooth_sum_reg[ch4] <= ssum_next;
        end
    end

    // stage 5: partial products of the first long divide
    assign a1_pl = ecgmbf_pkg::PL_W'(a1mag5_reg[ecgmbf_pkg::LO_W-1:0])
                   * ecgmbf_pkg::PL_W'(ecgmbf_pkg::LONG_M);
    assign a1_ph = ecgmbf_pkg::PH_W'(a1mag5_reg[ecgmbf_pkg::LONG_SUM_W-1:ecgmbf_pkg::LO_W])
                   * ecgmbf_pkg::PH_W'(ecgmbf_pkg::LONG_M);

    // stage 6: combine partials, take quotient
    assign a1_prod = (ecgmbf_pkg::LONG_PROD_W'(a1ph6_reg) << ecgmbf_pkg::LO_W)
                     + ecgmbf_pkg::LONG_PROD_W'(a1pl6_reg);
    assign a1_q    = a1_prod[ecgmbf_pkg::LONG_PROD_W-1:ecgmbf_pkg::LONG_S];

    // stage 7: first average with sign
    assign avg1_c = a1n7_reg ? -$signed(q1_7_reg) : $signed(q1_7_reg);

    // base ring memory: read in stage 7, write back in stage 8
    assign ch7  = ecgmbf_pkg::CH_W'(ctx_reg[7].chan);
    assign ch8  = ecgmbf_pkg::CH_W'(ctx_reg[8].chan);
    assign rd7  = adv && vld_reg[7] && ctx_reg[7].pres;
    assign wr8  = adv && vld_reg[8] && ctx_reg[8].pres;
    assign byp7 = wr8 && (ctx_reg[8].chan == ctx_reg[7].chan)
                  && (ctx_reg[8].lh == ctx_reg[7].lh);

    always_ff @(posedge clk)
    begin
        if (rd7)
        begin
            b_rd_reg       <= base_ring[ch7][ctx_reg[7].lh];
            b_byp_reg      <= byp7;
            b_byp_data_reg <= avg1_8_reg;
        end
        if (wr8)
        begin
            base_ring[ch8][ctx_reg[8].lh] <= avg1_8_reg;
        end
    end

    // stage 8: update base moving sum
    always_comb
    begin
        if (!ctx_reg[8].lfull)
        begin
            b_old = '0;
        end
        else if (b_byp_reg)
        begin
            b_old = b_byp_data_reg;
        end
        else
        begin
            b_old = b_rd_reg;
        end
        bsum_next = base_sum_reg[ch8] + ecgmbf_pkg::LONG_SUM_W'(avg1_8_reg)
                    - ecgmbf_pkg::LONG_SUM_W'(b_old);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ecgmbf_pkg::CHANNELS; i++)
            begin
                base_sum_reg[i] <= '0;
            end
        end
        else if (wr8)
        begin
            base_sum_reg[ch8] <= bsum_next;
        end
    end

    // stage 9: partial products of the second long divide
    assign a2_pl = ecgmbf_pkg::PL_W'(a2mag9_reg[ecgmbf_pkg::LO_W-1:0])
                   * ecgmbf_pkg::PL_W'(ecgmbf_pkg::LONG_M);
    assign a2_ph = ecgmbf_pkg::PH_W'(a2mag9_reg[ecgmbf_pkg::LONG_SUM_W-1:ecgmbf_pkg::LO_W])
                   * ecgmbf_pkg::PH_W'(ecgmbf_pkg::LONG_M);

    // stage 10: combine partials, take quotient
    assign a2_prod = (ecgmbf_pkg::LONG_PROD_W'(a2ph10_reg) << ecgmbf_pkg::LO_W)
                     + ecgmbf_pkg::LONG_PROD_W'(a2pl10_reg);
    assign a2_q    = a2_prod[ecgmbf_pkg::LONG_PROD_W-1:ecgmbf_pkg::LONG_S];

    // stage 11: smoothed value minus baseline
    always_comb
    begin
        if (!ctx_reg[ecgmbf_pkg::PIPE_STAGES].pres)
        begin
            res_c = '0;
        end
        else if (a2n11_reg)
        begin
            res_c = ecgmbf_pkg::RES_W'(smooth_reg[ecgmbf_pkg::PIPE_STAGES])
                    + ecgmbf_pkg::RES_W'(q2_11_reg);
        end
        else
        begin
            res_c = ecgmbf_pkg::RES_W'(smooth_reg[ecgmbf_pkg::PIPE_STAGES])
                    - ecgmbf_pkg::RES_W'(q2_11_reg);
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg     <= sample;
            rneg2_reg  <= raw_sum_next[ecgmbf_pkg::RAW_SUM_W-1];
            rmag2_reg  <= raw_sum_next[ecgmbf_pkg::RAW_SUM_W-1] ?
                          ecgmbf_pkg::RAW_SUM_W'(-raw_sum_next) :
                          ecgmbf_pkg::RAW_SUM_W'(raw_sum_next);
            rneg3_reg  <= rneg2_reg;
            rq3_reg    <= raw_prod[ecgmbf_pkg::RAW_PROD_W-1:ecgmbf_pkg::RAW_S];
            a1n5_reg   <= ssum_next[ecgmbf_pkg::LONG_SUM_W-1];
            a1mag5_reg <= ssum_next[ecgmbf_pkg::LONG_SUM_W-1] ?
                          ecgmbf_pkg::LONG_SUM_W'(-ssum_next) :
                          ecgmbf_pkg::LONG_SUM_W'(ssum_next);
            a1n6_reg   <= a1n5_reg;
            a1pl6_reg  <= a1_pl;
            a1ph6_reg  <= a1_ph;
            a1n7_reg   <= a1n6_reg;
            q1_7_reg   <= ecgmbf_pkg::SM_W'(a1_q);
            avg1_8_reg <= avg1_c;
            a2n9_reg   <= bsum_next[ecgmbf_pkg::LONG_SUM_W-1];
            a2mag9_reg <= bsum_next[ecgmbf_pkg::LONG_SUM_W-1] ?
                          ecgmbf_pkg::LONG_SUM_W'(-bsum_next) :
                          ecgmbf_pkg::LONG_SUM_W'(bsum_next);
            a2n10_reg  <= a2n9_reg;
            a2pl10_reg <= a2_pl;
            a2ph10_reg <= a2_ph;
            a2n11_reg  <= a2n10_reg;
            q2_11_reg  <= ecgmbf_pkg::SM_W'(a2_q);
            channel_out_reg <= ctx_reg[ecgmbf_pkg::PIPE_STAGES].chan;
            filtered_reg    <= $signed(res_c);
        end
    end

    // outputs
    assign rsp_valid   = rsp_valid_reg;
    assign channel_out = channel_out_reg;
    assign filtered    = filtered_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ECG mains and baseline filter. Requests go in
// with random gaps and results are taken with random backpressure, apart
// from the burst and hold-off tests; every result is compared with a
// cycle-free model of both filter stages kept per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_EVERY    = 120;

    localparam logic signed [ecgmbf_pkg::SMP_W-1:0] SMP_TOP =
        {1'b0, {(ecgmbf_pkg::SMP_W - 1){1'b1}}};
    localparam logic signed [ecgmbf_pkg::SMP_W-1:0] SMP_BOTTOM =
        {1'b1, {(ecgmbf_pkg::SMP_W - 1){1'b0}}};
    localparam longint SMP_HI    = (longint'(1) << (ecgmbf_pkg::SMP_W - 1)) - 1;
    localparam longint SMP_LO    = -(longint'(1) << (ecgmbf_pkg::SMP_W - 1));
    localparam longint SMOOTH_HI = (longint'(1) << (ecgmbf_pkg::SM_W - 1)) - 1;
    localparam longint SMOOTH_LO = -(longint'(1) << (ecgmbf_pkg::SM_W - 1));

    typedef struct packed {
        logic [ecgmbf_pkg::CHAN_W-1:0]       chan;
        logic signed [ecgmbf_pkg::RES_W-1:0] value;
    } filter_result_t;

    typedef enum int {
        SEG_WIDEBAND,
        SEG_ECG,
        SEG_LEVEL,
        SEG_RAMP,
        SEG_RAIL
    } segment_kind_t;

    logic                                clk;
    logic                                rst_n;
    logic                                req_valid;
    logic                                req_ready;
    logic [ecgmbf_pkg::CHAN_W-1:0]       channel;
    logic signed [ecgmbf_pkg::SMP_W-1:0] sample;
    logic                                rsp_valid;
    logic                                rsp_ready;
    logic [ecgmbf_pkg::CHAN_W-1:0]       channel_out;
    logic signed [ecgmbf_pkg::RES_W-1:0] filtered;

    // per-channel filter state of the prediction
    logic signed [ecgmbf_pkg::SMP_W-1:0]
        raw_taps [ecgmbf_pkg::CHANNELS][ecgmbf_pkg::MAINS_TAPS];
    logic signed [ecgmbf_pkg::SM_W-1:0]
        smooth_taps [ecgmbf_pkg::CHANNELS][ecgmbf_pkg::BASE_TAPS];
    logic signed [ecgmbf_pkg::SM_W-1:0]
        base_taps [ecgmbf_pkg::CHANNELS][ecgmbf_pkg::BASE_TAPS];
    longint                  raw_acc [ecgmbf_pkg::CHANNELS];
    longint                  smooth_acc [ecgmbf_pkg::CHANNELS];
    longint                  base_acc [ecgmbf_pkg::CHANNELS];
    int unsigned             raw_pos [ecgmbf_pkg::CHANNELS];
    int unsigned             long_pos [ecgmbf_pkg::CHANNELS];

    filter_result_t pending_results [$];
    int             mismatch_count = 0;
    int             hold_off_cycles = 0;
    bit             rsp_always_ready = 1'b0;
    bit             no_send_gaps = 1'b0;
    int             quiet_cycles = 0;

    ecg_mains_and_baseline_filter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .channel     (channel),
        .sample      (sample),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .channel_out (channel_out),
        .filtered    (filtered)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // clear all filter rings and sums
    function automatic void clear_filter_state();
        for (int c = 0; c < ecgmbf_pkg::CHANNELS; c++)
        begin
            raw_acc[c]    = 0;
            smooth_acc[c] = 0;
            base_acc[c]   = 0;
            raw_pos[c]    = 0;
            long_pos[c]   = 0;
            for (int i = 0; i < ecgmbf_pkg::MAINS_TAPS; i++)
                raw_taps[c][i] = '0;
            for (int i = 0; i < ecgmbf_pkg::BASE_TAPS; i++)
            begin
                smooth_taps[c][i] = '0;
                base_taps[c][i]   = '0;
            end
        end
    endfunction

    // advance one channel by one sample and return the filtered value
    function automatic filter_result_t predict_filtered(
        input logic [ecgmbf_pkg::CHAN_W-1:0] ch,
        input logic signed [ecgmbf_pkg::SMP_W-1:0] smp);
        filter_result_t r;
        longint         smooth;
        longint         mean1;
        longint         mean2;
        int unsigned    c;
        int unsigned    rp;
        int unsigned    lp;
        r.chan  = ch;
        r.value = '0;
        c = 32'(ch);
        // absent channel: state untouched, zero result
        if (c >= ecgmbf_pkg::CHANNELS)
            return r;

        // short moving sum, divided by half its length
        rp = raw_pos[c];
        raw_acc[c] += longint'(smp) - longint'(raw_taps[c][rp]);
        raw_taps[c][rp] = smp;
        raw_pos[c] = (rp + 1 >= ecgmbf_pkg::MAINS_TAPS) ? 0 : rp + 1;
        smooth = raw_acc[c] / longint'(ecgmbf_pkg::MAINS_TAPS / 2);
        if (smooth > SMOOTH_HI)
            smooth = SMOOTH_HI;
        if (smooth < SMOOTH_LO)
            smooth = SMOOTH_LO;

        // two cascaded long averages sharing one write position
        lp = long_pos[c];
        smooth_acc[c] += smooth - longint'(smooth_taps[c][lp]);
        smooth_taps[c][lp] = ecgmbf_pkg::SM_W'(smooth);
        mean1 = smooth_acc[c] / longint'(ecgmbf_pkg::BASE_TAPS);
        base_acc[c] += mean1 - longint'(base_taps[c][lp]);
        base_taps[c][lp] = ecgmbf_pkg::SM_W'(mean1);
        mean2 = base_acc[c] / longint'(ecgmbf_pkg::BASE_TAPS);
        long_pos[c] = (lp + 1 >= ecgmbf_pkg::BASE_TAPS) ? 0 : lp + 1;

        r.value = ecgmbf_pkg::RES_W'(smooth - mean2);
        return r;
    endfunction

    // offer one request, record its expected result, then maybe idle
    task automatic send_request(input logic [ecgmbf_pkg::CHAN_W-1:0] ch,
                                input logic signed [ecgmbf_pkg::SMP_W-1:0] smp);
        int gap;
        int pick;
        req_valid <= 1'b1;
        channel   <= ch;
        sample    <= smp;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_results.push_back(predict_filtered(ch, smp));
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!no_send_gaps)
        begin
            if (pick >= 90)
                gap = $urandom_range(12, 45);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // start-up from reset, rails on both channels, sign and bit patterns
    task automatic test_directed_extremes();
        repeat (6) send_request(1'b0, SMP_TOP);
        repeat (6) send_request(1'b1, SMP_BOTTOM);
        repeat (4) send_request(1'b0, SMP_BOTTOM);
        repeat (4) send_request(1'b1, SMP_TOP);
        send_request(1'b0, '0);
        send_request(1'b1, ecgmbf_pkg::SMP_W'(-1));
        send_request(1'b0, ecgmbf_pkg::SMP_W'(1));
        send_request(1'b1, {(ecgmbf_pkg::SMP_W / 2){2'b01}});
        send_request(1'b0, {(ecgmbf_pkg::SMP_W / 2){2'b10}});
        drain_results();
    endtask

    // back-to-back requests with the result side always ready
    task automatic test_full_rate_burst();
        no_send_gaps     = 1'b1;
        rsp_always_ready = 1'b1;
        repeat (40) send_request(ecgmbf_pkg::CHAN_W'($urandom),
                                 ecgmbf_pkg::SMP_W'($urandom));
        drain_results();
        no_send_gaps     = 1'b0;
        rsp_always_ready = 1'b0;
    endtask

    // result side held off long enough for the pipeline to fill and stall
    task automatic test_output_backpressure();
        hold_off_cycles = HOLD_OFF_LEN;
        no_send_gaps    = 1'b1;
        repeat (40) send_request(ecgmbf_pkg::CHAN_W'($urandom),
                                 ecgmbf_pkg::SMP_W'($urandom));
        no_send_gaps    = 1'b0;
        drain_results();
    endtask

    // signal-shaped segments per channel, with periodic drains
    task automatic test_random_stream(input int n_items);
        segment_kind_t                       kind;
        int                                  sent;
        int                                  since_drain;
        int                                  seg_len;
        bit                                  interleave;
        logic [ecgmbf_pkg::CHAN_W-1:0]       seg_ch;
        logic [ecgmbf_pkg::CHAN_W-1:0]       ch;
        logic signed [ecgmbf_pkg::SMP_W-1:0] smp;
        longint                              level;
        longint                              slope;
        longint                              v;
        sent        = 0;
        since_drain = 0;
        while (sent < n_items)
        begin
            kind       = segment_kind_t'($urandom_range(0, 4));
            seg_len    = $urandom_range(4, 40);
            interleave = ($urandom_range(0, 3) == 0);
            seg_ch     = ecgmbf_pkg::CHAN_W'($urandom_range(0,
                                                 (1 << ecgmbf_pkg::CHAN_W) - 1));
            level      = longint'($urandom_range(0, 1 << ecgmbf_pkg::SMP_W)) + SMP_LO;
            slope      = longint'($urandom_range(0, 100000)) - 50000;
            if (kind == SEG_ECG)
                level = level / 4;
            if (kind == SEG_RAIL)
                level = $urandom_range(0, 1) ? SMP_HI : SMP_LO;
            for (int i = 0; i < seg_len && sent < n_items; i++)
            begin
                ch = interleave ? ecgmbf_pkg::CHAN_W'($urandom) : seg_ch;
                case (kind)
                    SEG_ECG:
                    begin
                        v = level + longint'($urandom_range(0, 4000)) - 2000;
                        // periodic beat spike
                        if (i % 12 == 5)
                            v = v + 300000;
                    end
                    SEG_RAMP:
                        v = level + slope * i;
                    default:
                        v = level;
                endcase
                if (v > SMP_HI)
                    v = SMP_HI;
                if (v < SMP_LO)
                    v = SMP_LO;
                smp = (kind == SEG_WIDEBAND) ? ecgmbf_pkg::SMP_W'($urandom)
                                             : ecgmbf_pkg::SMP_W'(v);
                send_request(ch, smp);
                sent++;
                since_drain++;
                if (since_drain >= DRAIN_EVERY)
                begin
                    drain_results();
                    since_drain = 0;
                end
            end
        end
        drain_results();
    endtask

    // result side ready pattern, with the long hold-off counted here
    initial
    begin
        int lvl;
        int span;
        int pick;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                lvl  = 0;
                span = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else if (rsp_always_ready)
            begin
                lvl  = 1;
                span = 1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    lvl  = 1;
                    span = $urandom_range(1, 8);
                end
                else if (pick < 65)
                begin
                    lvl  = 1;
                    span = $urandom_range(20, 60);
                end
                else if (pick < 93)
                begin
                    lvl  = 0;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    lvl  = 0;
                    span = $urandom_range(10, 40);
                end
            end
            rsp_ready <= lvl[0];
            repeat (span - 1) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, channel_out %0d filtered %0d",
                         $time, channel_out, filtered);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (channel_out !== want.chan)
                begin
                    $display("%0t: channel_out mismatch, expected %0d, got %0d",
                             $time, want.chan, channel_out);
                    mismatch_count++;
                end
                if (filtered !== want.value)
                begin
                    $display("%0t: filtered mismatch on channel %0d, expected %0d, got %0d",
                             $time, want.chan, want.value, filtered);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request or result accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_results.size());
                $display("tb: errors");
                $finish;
            end
        end
    end

    // reset, test sequence and final verdict
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        channel   <= '0;
        sample    <= '0;
        clear_filter_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_full_rate_burst();
        test_output_backpressure();
        test_random_stream(495);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
